@@ hw/rtl/kfq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfq_pkg
// Shared types and constants for the keyed FIFO queue: sizes, operation
// codes, register map, payload structs and the slot memory request.
// ----------------------------------------------------------------------------
package kfq_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_WIDTH    = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int LEN_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(QUEUE_DEPTH);

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_WRITES_ALLOWED = 1'b0;   // word index of the register

    // operation codes
    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_QUERY   = 2'd2
    } op_t;

    // request payload
    typedef struct packed {
        logic [1:0]          operation;
        logic [ID_WIDTH-1:0] agent_id;
    } req_t;

    // response payload
    typedef struct packed {
        logic                ok;
        logic [IDX_W-1:0]    position;
        logic                full_res;
        logic                head_valid;
        logic [ID_WIDTH-1:0] head_id;
        logic [LEN_W-1:0]    length;
    } rsp_t;

    // slot memory access from the sequencer
    typedef struct packed {
        logic                we;
        logic [IDX_W-1:0]    waddr;
        logic [ID_WIDTH-1:0] wdata;
        logic [IDX_W-1:0]    raddr;
    } ram_req_t;

endpackage
`default_nettype wire

@@ hw/rtl/kfq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// A read of the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
module kfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ hw/rtl/kfq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfq_ctrl
// Request sequencer: scans the slot memory for the key, appends on enqueue,
// closes the gap on dequeue, and builds the response in an output register.
// ----------------------------------------------------------------------------
module kfq_ctrl
    import kfq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                writes_allowed,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire req_t                req,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output rsp_t                     rsp,
    output ram_req_t                 ram_req,
    input  wire logic [ID_WIDTH-1:0] ram_rdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_REPLY
    } state_t;

    state_t              state_reg,    state_next;
    logic [1:0]          op_reg,       op_next;
    logic [ID_WIDTH-1:0] id_reg,       id_next;
    logic [LEN_W-1:0]    len_reg,      len_next;
    logic [ID_WIDTH-1:0] head_reg,     head_next;
    logic [LEN_W-1:0]    issue_reg,    issue_next;
    logic                pend_reg,     pend_next;
    logic [IDX_W-1:0]    slot_reg,     slot_next;
    logic                ok_reg,       ok_next;
    logic [IDX_W-1:0]    pos_reg,      pos_next;
    logic                full_reg,     full_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg,      rsp_next;

    logic             hit;
    logic             miss_done;
    logic [LEN_W-1:0] issue_prev;
    logic [LEN_W-1:0] slot_plus;

    // compare of the slot read in the previous cycle
    assign hit        = pend_reg && (ram_rdata == id_reg);
    assign miss_done  = !hit && (issue_reg == len_reg);
    assign issue_prev = issue_reg - 1'b1;
    assign slot_plus  = LEN_W'(slot_reg) + 1'b1;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // next-state and datapath logic
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        len_next       = len_reg;
        head_next      = head_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        slot_next      = slot_reg;
        ok_next        = ok_reg;
        pos_next       = pos_reg;
        full_next      = full_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        ram_req.we     = 1'b0;
        ram_req.waddr  = slot_reg;
        ram_req.wdata  = ram_rdata;
        ram_req.raddr  = issue_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.operation;
                    id_next    = req.agent_id;
                    ok_next    = 1'b0;
                    pos_next   = '0;
                    full_next  = 1'b0;
                    issue_next = '0;
                    case (req.operation)
                        OP_ENQUEUE:
                        begin
                            state_next = (writes_allowed && (req.agent_id != '0)) ?
                                         ST_SCAN : ST_REPLY;
                        end
                        OP_DEQUEUE:
                        begin
                            state_next = writes_allowed ? ST_SCAN : ST_REPLY;
                        end
                        OP_QUERY:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_REPLY;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // issue the next slot read while comparing the last one
                if (!hit && (issue_reg < len_reg))
                begin
                    pend_next  = 1'b1;
                    slot_next  = issue_reg[IDX_W-1:0];
                    issue_next = issue_reg + 1'b1;
                end

                if (hit)
                begin
                    ok_next = 1'b1;
                    if (op_reg == OP_DEQUEUE)
                    begin
                        // start moving the entries behind the found slot
                        issue_next = slot_plus;
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        pos_next   = slot_reg;
                        state_next = ST_REPLY;
                    end
                end
                else if (miss_done)
                begin
                    if (op_reg == OP_ENQUEUE)
                    begin
                        if (len_reg == LEN_FULL)
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            // append at the tail
                            ram_req.we    = 1'b1;
                            ram_req.waddr = len_reg[IDX_W-1:0];
                            ram_req.wdata = id_reg;
                            if (len_reg == '0)
                            begin
                                head_next = id_reg;
                            end
                            pos_next = len_reg[IDX_W-1:0];
                            ok_next  = 1'b1;
                            len_next = len_reg + 1'b1;
                        end
                    end
                    state_next = ST_REPLY;
                end
            end

            ST_SHIFT:
            begin
                // write back the entry read last cycle one place up
                if (pend_reg)
                begin
                    ram_req.we = 1'b1;
                    if (slot_reg == '0)
                    begin
                        head_next = ram_rdata;
                    end
                end

                if (issue_reg < len_reg)
                begin
                    pend_next  = 1'b1;
                    slot_next  = issue_prev[IDX_W-1:0];
                    issue_next = issue_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    len_next   = len_reg - 1'b1;
                    state_next = ST_REPLY;
                end
            end

            ST_REPLY:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.ok         = ok_reg;
                    rsp_next.position   = pos_reg;
                    rsp_next.full_res   = full_reg;
                    rsp_next.head_valid = (len_reg != '0);
                    rsp_next.head_id    = (len_reg != '0) ? head_reg : '0;
                    rsp_next.length     = len_reg;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        id_reg    <= id_next;
        head_reg  <= head_next;
        issue_reg <= issue_next;
        slot_reg  <= slot_next;
        ok_reg    <= ok_next;
        pos_reg   <= pos_next;
        full_reg  <= full_next;
        rsp_reg   <= rsp_next;
    end

endmodule
`default_nettype wire

@@ hw/rtl/keyed_fifo_queue_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_fifo_queue_top
// Ordered queue of agent identifiers with enqueue, dequeue by key and
// position query; the queue lives in a 16-entry slot memory.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  req_t  (operation, agent_id)
//   rsp       out        rsp_valid/rsp_ready  rsp_t  (ok .. length)
//   apb       in         psel/penable/pready  writes_allowed at word 0
//
// A request is accepted in ST_IDLE, scanned in ST_SCAN with one slot read
// per cycle through the single read port of the slot memory, and answered
// from ST_REPLY; a dequeue that finds its agent first moves every agent
// behind the removed one up a place in ST_SHIFT. The next request is
// accepted once the reply is in the output register, even while it waits
// for rsp_ready.
// Reset empties the queue and sets writes_allowed; the slot memory needs no
// clearing because only entries below the length are read.
// ----------------------------------------------------------------------------
module keyed_fifo_queue_top
    import kfq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire req_t               req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output rsp_t                    rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    logic                writes_allowed_reg;
    ram_req_t            ram_req;
    logic [ID_WIDTH-1:0] ram_rdata;
    logic                cfg_wr;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WRITES_ALLOWED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            writes_allowed_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            writes_allowed_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_WRITES_ALLOWED) ?
                    PDATA_W'(writes_allowed_reg) : '0;

    // request sequencer
    kfq_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .writes_allowed (writes_allowed_reg),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .ram_req        (ram_req),
        .ram_rdata      (ram_rdata)
    );

    // slot memory
    kfq_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire

@@ hw/rtl/kfq_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfq_checker
// Port-level checks on the keyed FIFO queue responses, bound to the top.
// ----------------------------------------------------------------------------
module kfq_checker
    import kfq_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp
);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // length stays within the queue depth
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.length <= LEN_FULL)
        else $error("length beyond queue depth");

    // head flags agree with the length
    a_head: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.head_valid == (rsp.length != '0)) &&
                      (rsp.head_valid || (rsp.head_id == '0)))
        else $error("head does not match length");

    // a full rejection never reports success
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.full_res |-> !rsp.ok && (rsp.length == LEN_FULL))
        else $error("full flag with success or short queue");

    // failed operations report place zero
    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.ok |-> rsp.position == '0)
        else $error("position set on failure");

endmodule

bind keyed_fifo_queue_top kfq_checker u_kfq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
`default_nettype wire

@@ sim/kfq_queue_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfq_queue_checker
// Watches the request, response and register channels of the keyed FIFO
// queue, keeps a shadow copy of the queue, predicts one reply per accepted
// request and checks every reply transfer field by field, in order.
// ----------------------------------------------------------------------------
module kfq_queue_checker
    import kfq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    input  wire logic               req_ready,
    input  wire req_t               req,
    input  wire logic               rsp_valid,
    input  wire logic               rsp_ready,
    input  wire rsp_t               rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    input  wire logic               pready,
    output int unsigned             fail_count,
    output int unsigned             pending
);

    localparam logic [PADDR_W-1:0] WRITES_ALLOWED_ADDR = PADDR_W'({REG_WRITES_ALLOWED, 2'b00});

    // shadow queue, head at entry 0
    logic [ID_WIDTH-1:0] shadow_slots [QUEUE_DEPTH];
    int unsigned         shadow_len;
    logic                shadow_writes_allowed;

    // replies still owed by the block, oldest first
    rsp_t expected_replies [$];

    // place of an agent in the shadow queue, -1 when absent
    function automatic int find_agent(input logic [ID_WIDTH-1:0] id);
        if (id == '0)
            return -1;
        for (int i = 0; i < int'(shadow_len); i++)
            if (shadow_slots[i] == id)
                return i;
        return -1;
    endfunction

    // apply one request to the shadow queue and build the reply it causes
    task automatic predict_queue_op(input req_t item, output rsp_t reply);
        int where;
        where = -1;
        reply = '0;
        case (item.operation)
            OP_ENQUEUE:
            begin
                if (shadow_writes_allowed && item.agent_id != '0)
                begin
                    where = find_agent(item.agent_id);
                    if (where >= 0)
                    begin
                        reply.ok       = 1'b1;
                        reply.position = IDX_W'(where);
                    end
                    else if (shadow_len >= QUEUE_DEPTH)
                    begin
                        reply.full_res = 1'b1;
                    end
                    else
                    begin
                        shadow_slots[shadow_len] = item.agent_id;
                        reply.position           = IDX_W'(shadow_len);
                        reply.ok                 = 1'b1;
                        shadow_len++;
                    end
                end
            end
            OP_DEQUEUE:
            begin
                if (shadow_writes_allowed)
                begin
                    where = find_agent(item.agent_id);
                    if (where >= 0)
                    begin
                        // agents behind the removed one move up a place
                        for (int i = where; i + 1 < int'(shadow_len); i++)
                            shadow_slots[i] = shadow_slots[i + 1];
                        shadow_len--;
                        reply.ok = 1'b1;
                    end
                end
            end
            OP_QUERY:
            begin
                where = find_agent(item.agent_id);
                if (where >= 0)
                begin
                    reply.ok       = 1'b1;
                    reply.position = IDX_W'(where);
                end
            end
            default:
            begin
            end
        endcase
        reply.head_valid = (shadow_len > 0);
        reply.head_id    = (shadow_len > 0) ? shadow_slots[0] : '0;
        reply.length     = LEN_W'(shadow_len);
    endtask

    // one line per mismatch, each one counted
    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] reply mismatch: %s", $time, msg);
    endtask

    task automatic compare_reply(input rsp_t want, input rsp_t got);
        if (got.ok !== want.ok)
            report_mismatch($sformatf("ok expected %0d got %0d", want.ok, got.ok));
        if (got.position !== want.position)
            report_mismatch($sformatf("position expected %0d got %0d",
                                      want.position, got.position));
        if (got.full_res !== want.full_res)
            report_mismatch($sformatf("full_res expected %0d got %0d",
                                      want.full_res, got.full_res));
        if (got.head_valid !== want.head_valid)
            report_mismatch($sformatf("head_valid expected %0d got %0d",
                                      want.head_valid, got.head_valid));
        if (got.head_id !== want.head_id)
            report_mismatch($sformatf("head_id expected %h got %h",
                                      want.head_id, got.head_id));
        if (got.length !== want.length)
            report_mismatch($sformatf("length expected %0d got %0d",
                                      want.length, got.length));
    endtask

    // channel monitor: replies first, then register writes, then requests
    always @(posedge clk or negedge rst_n)
    begin : monitor
        rsp_t want;
        rsp_t predicted;
        if (!rst_n)
        begin
            shadow_len            = 0;
            shadow_writes_allowed = 1'b1;
            expected_replies.delete();
            fail_count            = 0;
            pending               = 0;
        end
        else
        begin
            // reply transfer
            if (rsp_valid && rsp_ready)
            begin
                if (expected_replies.size() == 0)
                    report_mismatch("reply transfer with no request outstanding");
                else
                begin
                    want = expected_replies.pop_front();
                    compare_reply(want, rsp);
                end
            end
            // register write
            if (psel && penable && pwrite && pready && paddr == WRITES_ALLOWED_ADDR)
                shadow_writes_allowed = pwdata[0];
            // request transfer
            if (req_valid && req_ready)
            begin
                predict_queue_op(req, predicted);
                expected_replies.push_back(predicted);
            end
            pending = expected_replies.size();
        end
    end

endmodule

@@ sim/keyed_fifo_queue_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_fifo_queue_top_tb
// Drives the keyed FIFO queue with directed corner cases and then with
// segments of random enqueue, dequeue and query requests over a small agent
// pool, under random idling, a long response stall and drained pauses, with
// writes toggled on and off through the register port.
// ----------------------------------------------------------------------------
module keyed_fifo_queue_top_tb;
    import kfq_pkg::*;

    localparam logic [1:0]         OP_UNKNOWN          = 2'd3;
    localparam logic [PADDR_W-1:0] WRITES_ALLOWED_ADDR = PADDR_W'({REG_WRITES_ALLOWED, 2'b00});
    localparam int ID_POOL_SIZE     = 24;
    localparam int NUM_SEGMENTS     = 14;
    localparam int SEGMENT_ITEMS    = 100;
    localparam int LOCKED_ITEMS     = 50;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES     = 40;
    localparam int TIMEOUT_NS       = 5_000_000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    req_t               req;
    logic               rsp_valid;
    logic               rsp_ready;
    rsp_t               rsp;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int unsigned fail_count;
    int unsigned pending;

    // sender and receiver control, written by the stimulus process only
    bit          rsp_steady;
    int unsigned hold_requests;
    bit          req_steady;

    logic [ID_WIDTH-1:0] id_pool [ID_POOL_SIZE];

    always #6 clk = ~clk;

    keyed_fifo_queue_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    kfq_queue_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // request transfer after a random gap unless req_steady, payload held until accepted
    task automatic send_request(input logic [1:0] op, input logic [ID_WIDTH-1:0] id);
        int gap;
        gap = req_steady ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.operation = op;
        req.agent_id  = id;
        req_valid     = 1'b1;
        do @(posedge clk); while (!req_ready);
    endtask

    // stop offering and wait until every reply has come back
    task automatic wait_drained();
        @(negedge clk);
        req_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // setup and access phase of a register write
    task automatic write_writes_allowed(input logic value);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = WRITES_ALLOWED_ADDR;
        pwdata  = {31'($urandom), value};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // mostly pool agents with a biased operation mix, some noise
    task automatic send_random_request(input int enq_pct, input int deq_pct);
        int                  roll;
        logic [1:0]          op;
        logic [ID_WIDTH-1:0] id;
        roll = $urandom_range(0, 99);
        if (roll < 6)
        begin
            op = 2'($urandom_range(0, 3));
            id = $urandom_range(0, 1) ? '0 : ID_WIDTH'($urandom);
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < enq_pct)
                op = OP_ENQUEUE;
            else if (roll < enq_pct + deq_pct)
                op = OP_DEQUEUE;
            else
                op = OP_QUERY;
            id = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
        end
        send_request(op, id);
    endtask

    // response side: random stalls, steady stretches, one long hold-off
    initial
    begin : reply_sink
        int          stall;
        int unsigned holds_served;
        holds_served = 0;
        rsp_ready    = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                rsp_ready    = 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end
            stall = rsp_steady ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                rsp_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready = 1'b1;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        int enq_pct;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        rsp_steady    = 1'b0;
        req_steady    = 1'b0;
        hold_requests = 0;

        // agent pool with the extreme identifiers up front
        id_pool[0] = '1;
        id_pool[1] = ID_WIDTH'(1);
        id_pool[2] = {1'b1, {(ID_WIDTH - 1){1'b0}}};
        for (int i = 3; i < ID_POOL_SIZE; i++)
        begin
            id_pool[i] = ID_WIDTH'($urandom);
            if (id_pool[i] == '0)
                id_pool[i] = ID_WIDTH'(2);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty queue, invalid identifier, repeat enqueue, unknown operation
        send_request(OP_QUERY, ID_WIDTH'(5));
        send_request(OP_DEQUEUE, ID_WIDTH'(5));
        send_request(OP_ENQUEUE, '0);
        send_request(OP_ENQUEUE, id_pool[0]);
        send_request(OP_ENQUEUE, id_pool[0]);
        send_request(OP_UNKNOWN, id_pool[0]);
        send_request(OP_DEQUEUE, '0);
        // fill to the brim, then full and already-queued cases
        for (int i = 1; i < QUEUE_DEPTH; i++)
            send_request(OP_ENQUEUE, id_pool[i]);
        send_request(OP_ENQUEUE, id_pool[QUEUE_DEPTH]);
        send_request(OP_ENQUEUE, id_pool[9]);
        send_request(OP_QUERY, id_pool[QUEUE_DEPTH - 1]);
        send_request(OP_DEQUEUE, id_pool[0]);
        send_request(OP_DEQUEUE, id_pool[7]);

        // writes disabled: enqueue and dequeue refused, query still works
        wait_drained();
        write_writes_allowed(1'b0);
        send_request(OP_ENQUEUE, id_pool[20]);
        send_request(OP_DEQUEUE, id_pool[1]);
        send_request(OP_ENQUEUE, id_pool[1]);
        send_request(OP_QUERY, id_pool[1]);
        wait_drained();
        write_writes_allowed(1'b1);

        // random segments, each with its own operation mix and idling style
        for (int seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            if (seg == 3)
                hold_requests++;
            if (seg == 7)
                wait_drained();
            if (seg == 9)
            begin
                wait_drained();
                write_writes_allowed(1'b0);
                for (int i = 0; i < LOCKED_ITEMS; i++)
                    send_random_request(40, 40);
                wait_drained();
                write_writes_allowed(1'b1);
            end
            case ($urandom_range(0, 3))
                0:       enq_pct = 70;
                1:       enq_pct = 55;
                2:       enq_pct = 35;
                default: enq_pct = 15;
            endcase
            req_steady = ($urandom_range(0, 3) == 0);
            rsp_steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < SEGMENT_ITEMS; i++)
                send_random_request(enq_pct, (100 - enq_pct) * 2 / 3);
        end

        // drain and settle
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
